>>> hdl/assert_macros.svh
// Assertion macros shared by the deframer modules.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfd assertion failed");

// Condition that must never hold outside reset.
`define TFD_NEVER(label, clk, rst_n, cond) \
  `TFD_ASSERT(label, clk, rst_n, !(cond))

`endif

>>> hdl/tfd_pkg.sv
// Shared types and constants of the tiled frame packet deframer.
// No dependencies; imported by every module of the block.
package tfd_pkg;

  localparam int unsigned MaxPacketBytes = 16777216;
  localparam int unsigned OffW = 24;
  localparam logic [OffW-1:0] OffsetCap = OffW'(MaxPacketBytes - 1);

  localparam logic [3:0] PhHeader  = 4'd0;
  localparam logic [3:0] PhField   = 4'd1;
  localparam logic [3:0] PhPayload = 4'd13;
  localparam logic [3:0] PhDone    = 4'd14;

  localparam logic [31:0] HeaderBytes = 32'd14;

  localparam logic [1:0] KindDecode = 2'd0;
  localparam logic [1:0] KindSkip   = 2'd1;
  localparam logic [1:0] KindFrame  = 2'd2;

  localparam logic RegVersion  = 1'b0;
  localparam logic RegEncoding = 1'b1;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = 8'h46;
      2'd1: m = 8'h52;
      2'd2: m = 8'h41;
      default: m = 8'h4D;
    endcase
    return m;
  endfunction

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        packet_end;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] tile_w;
    logic [15:0] tile_h;
    logic [23:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] frame_tag;
    logic [15:0] tiles_in_frame;
    logic [31:0] bytes_in_frame;
    logic [31:0] frame_elapsed;
    logic        last_of_run;
  } result_t;

  // Everything one byte produced: an optional tile and an optional frame summary.
  typedef struct packed {
    logic        tile_v;
    logic [1:0]  tile_kind;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] tile_w;
    logic [15:0] tile_h;
    logic [23:0] payload_offset;
    logic [31:0] payload_length;
    logic        frame_v;
    logic [31:0] frame_tag;
    logic [15:0] tiles_in_frame;
    logic [31:0] bytes_in_frame;
    logic [31:0] frame_elapsed;
  } event_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> hdl/tile_frame_packet_deframer_unit.sv
// Top level of the tiled frame packet deframer.
// Depends on tfd_pkg, tfd_front, tfd_queue and tfd_back.
//
// Usage: packet bytes enter through a queue-style port. A transaction is
// accepted on a clock edge with push high and full low; each carries one
// byte, its end-of-packet mark and a millisecond timestamp. Results leave
// through a second queue-style port: while empty is low the oldest result
// sits on result_o, and it is taken on an edge with pop high.
// The parser handles one byte per cycle while full is low. A byte that
// completes a tile (or ends a packet with a frame summary) is written into
// a four-entry event queue; its first result reaches result_o through the
// queue and output register. A byte with a tile and a frame summary gives
// two results, tile first. When the receiver stalls, the output register
// holds its result, the event queue fills, and full rises once four events
// wait; bytes that cause no result still need a free slot to be taken.
// Two configuration registers sit on the APB port: the accepted version at
// address 0 (reset 1) and the encoding marked for decoding at address 4
// (reset 2). Reset clears the parser, the frame counters (frame id all
// ones), the event queue and output register; no clearing pass is needed.
module tile_frame_packet_deframer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tfd_pkg::in_item_t in_item_i,
  output logic              empty,
  input  logic              pop,
  output tfd_pkg::result_t  result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tfd_pkg::*;

  logic [7:0] version_q, encoding_q;
  logic       accept, ev_push, q_pop;
  event_t     ev, head;
  q_status_t  q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegEncoding) ? {24'h0, encoding_q} : {24'h0, version_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 8'd1;
      encoding_q <= 8'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegVersion) version_q <= pwdata[7:0];
      else encoding_q <= pwdata[7:0];
    end
  end

  // Full follows the event queue, so a byte is only taken when any result
  // it may produce has room.
  assign full = q_status.full;
  assign accept = push && !q_status.full;

  tfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .version_i  (version_q),
    .encoding_i (encoding_q),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .ev_push_o  (ev_push),
    .ev_o       (ev)
  );

  tfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ev_push),
    .ev_i     (ev),
    .pop_i    (q_pop),
    .head_o   (head),
    .status_o (q_status)
  );

  tfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );
endmodule

>>> hdl/tfd_front.sv
// Byte parser of the deframer: header, tile records and payload tracking.
// Depends on tfd_pkg; writes one event per byte that produces results.
`include "assert_macros.svh"
module tfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        version_i,
  input  logic [7:0]        encoding_i,
  input  logic              accept_i,
  input  tfd_pkg::in_item_t item_i,
  output logic              ev_push_o,
  output tfd_pkg::event_t   ev_o
);
  import tfd_pkg::*;

  logic [3:0]        phase_q, phase_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [31:0]       fs_q, fs_d;
  logic [7:0]        enc_q, enc_d;
  logic [15:0]       trem_q, trem_d;
  logic              flag_q, flag_d;
  logic [3:0][15:0]  tf_q, tf_d;
  logic [31:0]       prem_q, prem_d;
  logic [OffW-1:0]   pstart_q, pstart_d;
  logic [31:0]       frame_q, frame_d;
  logic [31:0]       fstart_q, fstart_d;
  logic [15:0]       tcnt_q, tcnt_d;
  logic [31:0]       fbytes_q, fbytes_d;
  logic              abort_q, abort_d;
  logic              fin, frame_done;
  logic [3:0]        r;
  logic [7:0]        b;
  logic [OffW-1:0]   idx;

  always_comb begin
    b = item_i.packet_byte;
    idx = off_q;
    r = phase_q - 4'd1;
    phase_d = phase_q;
    off_d = (off_q < OffsetCap) ? off_q + OffW'(1) : off_q;
    fs_d = fs_q;
    enc_d = enc_q;
    trem_d = trem_q;
    flag_d = flag_q;
    tf_d = tf_q;
    prem_d = prem_q;
    pstart_d = pstart_q;
    frame_d = frame_q;
    fstart_d = fstart_q;
    tcnt_d = tcnt_q;
    fbytes_d = fbytes_q;
    abort_d = abort_q;
    fin = 1'b0;
    if (!abort_q) begin
      if (phase_q == PhHeader) begin
        if (idx < OffW'(4)) begin
          if (b != magic_byte(idx[1:0])) abort_d = 1'b1;
        end else begin
          case (idx)
            OffW'(4): if (b != version_i) abort_d = 1'b1;
            OffW'(5): fs_d = {24'h0, b};
            OffW'(6): fs_d[15:8] = b;
            OffW'(7): fs_d[23:16] = b;
            OffW'(8): fs_d[31:24] = b;
            OffW'(9): enc_d = b;
            OffW'(10): trem_d = {8'h0, b};
            OffW'(11): trem_d[15:8] = b;
            OffW'(12): flag_d = b[0];
            default: begin
              if (fs_q != frame_q) begin
                frame_d = fs_q;
                fstart_d = item_i.time_ms;
                tcnt_d = '0;
                fbytes_d = HeaderBytes;
              end else begin
                fbytes_d = fbytes_q + HeaderBytes;
              end
              phase_d = (trem_q != '0) ? PhField : PhDone;
            end
          endcase
        end
      end else begin
        fbytes_d = fbytes_q + 32'd1;
        if (phase_q >= PhField && phase_q < PhPayload) begin
          if (r < 4'd8) begin
            if (!r[0]) tf_d[r[2:1]] = {8'h0, b};
            else tf_d[r[2:1]][15:8] = b;
            phase_d = phase_q + 4'd1;
          end else begin
            case (r[1:0])
              2'd0: fs_d = {24'h0, b};
              2'd1: fs_d[15:8] = b;
              2'd2: fs_d[23:16] = b;
              default: fs_d[31:24] = b;
            endcase
            if (r[1:0] == 2'd3) begin
              prem_d = fs_d;
              pstart_d = off_d;
              if (fs_d == '0) fin = 1'b1;
              else phase_d = PhPayload;
            end else begin
              phase_d = phase_q + 4'd1;
            end
          end
        end else if (phase_q == PhPayload) begin
          prem_d = prem_q - 32'd1;
          if (prem_d == '0) fin = 1'b1;
        end
      end
    end
    if (fin) begin
      tcnt_d = tcnt_d + 16'd1;
      trem_d = trem_d - 16'd1;
      phase_d = (trem_d != '0) ? PhField : PhDone;
    end
    frame_done = item_i.packet_end && !abort_d && phase_d == PhDone && flag_d;

    ev_o.tile_v = fin;
    ev_o.tile_kind = (enc_d == encoding_i && fs_d != '0) ? KindDecode : KindSkip;
    ev_o.tile_x = tf_d[0];
    ev_o.tile_y = tf_d[1];
    ev_o.tile_w = tf_d[2];
    ev_o.tile_h = tf_d[3];
    ev_o.payload_offset = pstart_d;
    ev_o.payload_length = fs_d;
    ev_o.frame_v = frame_done;
    ev_o.frame_tag = frame_d;
    ev_o.tiles_in_frame = tcnt_d;
    ev_o.bytes_in_frame = fbytes_d;
    ev_o.frame_elapsed = item_i.time_ms - fstart_d;
    ev_push_o = accept_i && (fin || frame_done);

    // The end mark always restarts the parse for the next packet.
    if (item_i.packet_end) begin
      phase_d = PhHeader;
      off_d = '0;
      fs_d = '0;
      enc_d = '0;
      trem_d = '0;
      flag_d = 1'b0;
      tf_d = '0;
      prem_d = '0;
      pstart_d = '0;
      abort_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      off_q <= '0;
      fs_q <= '0;
      enc_q <= '0;
      trem_q <= '0;
      flag_q <= 1'b0;
      tf_q <= '0;
      prem_q <= '0;
      pstart_q <= '0;
      frame_q <= '1;
      fstart_q <= '0;
      tcnt_q <= '0;
      fbytes_q <= '0;
      abort_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      off_q <= off_d;
      fs_q <= fs_d;
      enc_q <= enc_d;
      trem_q <= trem_d;
      flag_q <= flag_d;
      tf_q <= tf_d;
      prem_q <= prem_d;
      pstart_q <= pstart_d;
      frame_q <= frame_d;
      fstart_q <= fstart_d;
      tcnt_q <= tcnt_d;
      fbytes_q <= fbytes_d;
      abort_q <= abort_d;
    end
  end

  `TFD_ASSERT(a_frame_on_end, clk_i, rst_ni, ev_push_o && ev_o.frame_v |-> item_i.packet_end)
  `TFD_NEVER(a_phase_range, clk_i, rst_ni, phase_q == 4'd15)
endmodule

>>> hdl/tfd_queue.sv
// Short event queue between the byte parser and the result formatter.
// Depends on tfd_pkg for the event type and depth.
`include "assert_macros.svh"
module tfd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tfd_pkg::event_t     ev_i,
  input  logic                pop_i,
  output tfd_pkg::event_t     head_o,
  output tfd_pkg::q_status_t  status_o
);
  import tfd_pkg::*;

  event_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign head_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ev_i;
  end

  `TFD_NEVER(a_no_overflow, clk_i, rst_ni, push_i && status_o.full && !pop_i)
  `TFD_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && status_o.empty)
endmodule

>>> hdl/tfd_back.sv
// Result formatter: splits each event into one or two results and holds
// the oldest one in an output register. Depends on tfd_pkg.
`include "assert_macros.svh"
module tfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfd_pkg::event_t     head_i,
  input  tfd_pkg::q_status_t  q_status_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tfd_pkg::result_t    result_o
);
  import tfd_pkg::*;

  logic    valid_q;
  logic    second_q, second_d;
  logic    load;
  result_t res_q, res_d;

  assign load = (!valid_q || (pop_i && valid_q)) && !q_status_i.empty;
  assign empty_o = !valid_q;
  assign result_o = res_q;

  always_comb begin
    res_d = '0;
    res_d.frame_tag = head_i.frame_tag;
    res_d.tiles_in_frame = head_i.tiles_in_frame;
    res_d.bytes_in_frame = head_i.bytes_in_frame;
    second_d = second_q;
    q_pop_o = 1'b0;
    if (head_i.tile_v && !second_q) begin
      res_d.result_kind = head_i.tile_kind;
      res_d.tile_x = head_i.tile_x;
      res_d.tile_y = head_i.tile_y;
      res_d.tile_w = head_i.tile_w;
      res_d.tile_h = head_i.tile_h;
      res_d.payload_offset = head_i.payload_offset;
      res_d.payload_length = head_i.payload_length;
      res_d.last_of_run = !head_i.frame_v;
      if (head_i.frame_v) second_d = 1'b1;
      else q_pop_o = load;
    end else begin
      res_d.result_kind = KindFrame;
      res_d.frame_elapsed = head_i.frame_elapsed;
      res_d.last_of_run = 1'b1;
      second_d = 1'b0;
      q_pop_o = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        second_q <= second_d;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  `TFD_NEVER(a_second_has_head, clk_i, rst_ni, second_q && q_status_i.empty)
endmodule
